[hw/rtl/cursor_sprite_alpha_overlay_defines.svh]
// Assertion helpers for the cursor overlay.
`ifndef CURSOR_SPRITE_ALPHA_OVERLAY_DEFINES_SVH
`define CURSOR_SPRITE_ALPHA_OVERLAY_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CSAO_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cursor overlay check failed");

// Next-cycle implication, disabled while in reset.
`define CSAO_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cursor overlay check failed");

`endif

[hw/rtl/csao_pkg.sv]
`default_nettype none

package csao_pkg;

  localparam int SPRITE_WIDTH  = 16;
  localparam int SPRITE_HEIGHT = 20;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;

  localparam int CFG_W  = 13;
  localparam int ADDR_W = 2;

  localparam logic [ADDR_W-1:0] REG_CURSOR_X       = 2'd0;
  localparam logic [ADDR_W-1:0] REG_CURSOR_Y       = 2'd1;
  localparam logic [ADDR_W-1:0] REG_CURSOR_VISIBLE = 2'd2;

  localparam logic [31:0] SHADOW_ARGB  = 32'h4000_0000;
  localparam logic [31:0] OUTLINE_ARGB = 32'hFF00_0000;
  localparam logic [31:0] FILL_ARGB    = 32'hFFFF_FFFF;
  localparam logic [31:0] CLEAR_ARGB   = 32'h0000_0000;

  // 2-bit sprite pixel codes held in the ROM
  typedef enum logic [1:0] {
    SPR_CLEAR   = 2'd0,
    SPR_SHADOW  = 2'd1,
    SPR_OUTLINE = 2'd2,
    SPR_FILL    = 2'd3
  } spr_code_t;

  typedef enum logic [1:0] {
    MIX_PASS   = 2'd0,
    MIX_OPAQUE = 2'd1,
    MIX_BLEND  = 2'd2
  } mix_kind_t;

  localparam int ROW_W = SPRITE_WIDTH * 2;
  localparam int ROM_W = ROW_W * SPRITE_HEIGHT;

  // Width of the arrow in each sprite row
  function automatic int arrow_span(input int r);
    int w;
    case (r)
      0: w = 1;   1: w = 2;   2: w = 3;   3: w = 4;
      4: w = 5;   5: w = 6;   6: w = 7;   7: w = 8;
      8: w = 9;   9: w = 10;  10: w = 11; 11: w = 12;
      12: w = 7;  13: w = 5;  14: w = 6;  15: w = 5;
      16: w = 4;  17: w = 3;  18: w = 2;  19: w = 1;
      default: w = 0;
    endcase
    return w;
  endfunction

  function automatic spr_code_t sprite_code(input int r, input int c);
    int        w;
    logic      is_edge;
    spr_code_t code;
    w    = arrow_span(r);
    code = SPR_CLEAR;
    if (c < w) begin
      is_edge = (c == 0) || (c == w - 1) || (r == 0) ||
                (r < SPRITE_HEIGHT - 1 && c >= arrow_span(r + 1)) ||
                (r > 0 && c >= arrow_span(r - 1));
      code = is_edge ? SPR_OUTLINE : SPR_FILL;
    end else if (c >= 1) begin
      if (r >= 1 && c - 1 < arrow_span(r - 1))
        code = SPR_SHADOW;
      else if (r == SPRITE_HEIGHT - 1 && c - 1 < w)
        code = SPR_SHADOW;
    end
    return code;
  endfunction

  // Whole sprite packed row by row, two bits per pixel, column 0 lowest
  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] rom;
    rom = '0;
    for (int r = 0; r < SPRITE_HEIGHT; r++) begin
      for (int c = 0; c < SPRITE_WIDTH; c++) begin
        rom[r*ROW_W + c*2 +: 2] = sprite_code(r, c);
      end
    end
    return rom;
  endfunction

  localparam logic [ROM_W-1:0] SPRITE_ROM = build_rom();

  function automatic logic [31:0] code_argb(input logic [1:0] code);
    logic [31:0] argb;
    case (code)
      SPR_SHADOW:  argb = SHADOW_ARGB;
      SPR_OUTLINE: argb = OUTLINE_ARGB;
      SPR_FILL:    argb = FILL_ARGB;
      default:     argb = CLEAR_ARGB;
    endcase
    return argb;
  endfunction

  // floor(x / 255) for x < 65280
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] t;
    logic [16:0] u;
    t = x + 17'd1;
    u = t + (t >> 8);
    return u[15:8];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cursor_sprite_alpha_overlay.sv]
// Hardware cursor overlay on a pixel stream.
// in_*  : one item per screen pixel; tdata = {background, pixel_y, pixel_x}.
// out_* : one item per input item, same order; tdata = shown_pixel (0xXXRRGGBB).
// cfg_* : register writes (0 cursor_x, 1 cursor_y, 2 cursor_visible), one per
//         cycle while cfg_we is high; other indexes are dropped. Write only while
//         the pipe is empty, since items in flight read the registers at entry.
// Pipeline: four register stages (position subtract, sprite ROM lookup,
// per-channel 8x8 multiplies, divide by 255 and select into the output
// register). Throughput: one item per cycle while out_tready is high; every
// stage has its own valid bit and bubbles are squeezed out, so the input keeps
// flowing until the pipe is truly full.
// Receiver stall: out_tdata holds, stages fill up behind it and in_tready drops
// once all four stages are occupied; nothing is lost or repeated.
// Reset (rst_n low, synchronous): pipe emptied, cursor at (0,0) and hidden.
// Pixels off screen, outside the sprite box, or with the cursor hidden pass the
// background through unchanged.
`default_nettype none

`include "cursor_sprite_alpha_overlay_defines.svh"

module cursor_sprite_alpha_overlay (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // config write port
  input  wire logic                        cfg_we,
  input  wire logic [csao_pkg::ADDR_W-1:0] cfg_addr,
  input  wire logic [csao_pkg::CFG_W-1:0]  cfg_wdata,
  // input pixel stream
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [55:0]                 in_tdata,  // [11:0] pixel_x, [23:12] pixel_y,
                                                      // [55:24] background
  // output pixel stream
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [31:0]                 out_tdata  // [31:0] shown_pixel
);
  import csao_pkg::*;

  // ---------------- config registers ----------------
  logic [12:0] cx_r;
  logic [12:0] cy_r;
  logic        vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      vis_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CURSOR_X:       cx_r  <= cfg_wdata;
        REG_CURSOR_Y:       cy_r  <= cfg_wdata;
        REG_CURSOR_VISIBLE: vis_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage enables ----------------
  // A stage loads when it is empty or its contents move on.
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: offsets into the sprite ----------------
  logic [11:0] px, py;
  logic [31:0] bg_in;
  logic [13:0] dx_nxt, dy_nxt;
  logic        on_nxt;

  assign px    = in_tdata[11:0];
  assign py    = in_tdata[23:12];
  assign bg_in = in_tdata[55:24];

  // 14 bits hold px - cx for any 12-bit pixel and 13-bit signed corner
  assign dx_nxt = {2'b00, px} - {cx_r[12], cx_r};
  assign dy_nxt = {2'b00, py} - {cy_r[12], cy_r};
  // 13-bit compare so a screen of 4096 still fits
  assign on_nxt = vis_r && ({1'b0, px} < 13'(SCREEN_WIDTH)) &&
                  ({1'b0, py} < 13'(SCREEN_HEIGHT));

  logic [13:0] dx1_r, dy1_r;
  logic        on1_r;
  logic [31:0] bg1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      dx1_r <= dx_nxt;
      dy1_r <= dy_nxt;
      on1_r <= on_nxt;
      bg1_r <= bg_in;
    end
  end

  // ---------------- stage 2: box test and ROM lookup ----------------
  logic       in_box;
  logic [9:0] rom_idx;
  logic [1:0] code;
  logic [31:0] sp_nxt;

  // non-negative and below the sprite size
  assign in_box = on1_r &&
                  !dx1_r[13] && (dx1_r < 14'(SPRITE_WIDTH)) &&
                  !dy1_r[13] && (dy1_r < 14'(SPRITE_HEIGHT));

  assign rom_idx = {dy1_r[4:0], dx1_r[3:0], 1'b0};
  assign code    = SPRITE_ROM[rom_idx +: 2];
  assign sp_nxt  = in_box ? code_argb(code) : CLEAR_ARGB;

  logic [31:0] sp2_r;
  logic [31:0] bg2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      sp2_r <= sp_nxt;
      bg2_r <= bg1_r;
    end
  end

  // ---------------- stage 3: per-channel products ----------------
  logic [7:0] alpha, inv_alpha;
  mix_kind_t  kind_nxt;
  logic [15:0] ps_nxt [3];
  logic [15:0] pb_nxt [3];

  assign alpha     = sp2_r[31:24];
  assign inv_alpha = 8'hFF - alpha;

  always_comb begin
    if (alpha == 8'h00)      kind_nxt = MIX_PASS;
    else if (alpha == 8'hFF) kind_nxt = MIX_OPAQUE;
    else                     kind_nxt = MIX_BLEND;
    for (int ch = 0; ch < 3; ch++) begin
      ps_nxt[ch] = sp2_r[ch*8 +: 8] * alpha;
      pb_nxt[ch] = bg2_r[ch*8 +: 8] * inv_alpha;
    end
  end

  mix_kind_t   kind3_r;
  logic [23:0] rgb3_r;
  logic [31:0] bg3_r;
  logic [15:0] ps3_r [3];
  logic [15:0] pb3_r [3];

  always_ff @(posedge clk) begin
    if (en3) begin
      kind3_r <= kind_nxt;
      rgb3_r  <= sp2_r[23:0];
      bg3_r   <= bg2_r;
      for (int ch = 0; ch < 3; ch++) begin
        ps3_r[ch] <= ps_nxt[ch];
        pb3_r[ch] <= pb_nxt[ch];
      end
    end
  end

  // ---------------- stage 4: divide by 255 and select ----------------
  logic [23:0] blend;
  logic [31:0] res_nxt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      blend[ch*8 +: 8] = div255({1'b0, ps3_r[ch]} + {1'b0, pb3_r[ch]});
    end
    case (kind3_r)
      MIX_OPAQUE: res_nxt = {8'h00, rgb3_r};
      MIX_BLEND:  res_nxt = {8'h00, blend};
      default:    res_nxt = bg3_r;
    endcase
  end

  logic [31:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (en4) out_tdata_r <= res_nxt;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- checks ----------------
  // Full pipe behind a stalled receiver must refuse input.
  `CSAO_CHECK(a_full_stall, v1_r && v2_r && v3_r && v4_r && !out_tready, !in_tready)
  // Pass-through items leave the background unchanged.
  `CSAO_CHECK_NEXT(a_pass_bg, v3_r && en4 && (kind3_r == MIX_PASS), out_tdata == $past(bg3_r))
  // Overlaid items always carry a zero top byte.
  `CSAO_CHECK_NEXT(a_top_zero, v3_r && en4 && (kind3_r != MIX_PASS), out_tdata[31:24] == 8'h00)

endmodule

`default_nettype wire
